// ===== rtl/sv32ptw_pkg.sv =====
// Shared types, codes and helper functions for the Sv32 page table walker.
// Depends on nothing; every other file of the block imports it.
package sv32ptw_pkg;

  localparam int unsigned CfgIndexWidth = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_VIRTUAL_MODE = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ROOT_BASE    = 8'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RAM_BEGIN    = 8'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_RAM_SIZE     = 8'd3;

  // Access type codes.
  localparam logic [1:0] ACC_READ   = 2'd0;
  localparam logic [1:0] ACC_WRITE  = 2'd1;
  localparam logic [1:0] ACC_FETCH  = 2'd2;
  localparam logic [1:0] ACC_SPARE  = 2'd3;

  // Fault cause codes.
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_LOAD  = 2'd1;
  localparam logic [1:0] CAUSE_STORE = 2'd2;
  localparam logic [1:0] CAUSE_FETCH = 2'd3;

  // Page table entry flag masks.
  localparam logic [31:0] PTE_V        = 32'h0000_0001;
  localparam logic [31:0] PTE_R        = 32'h0000_0002;
  localparam logic [31:0] PTE_W        = 32'h0000_0004;
  localparam logic [31:0] PTE_X        = 32'h0000_0008;
  localparam logic [31:0] PTE_RWX      = 32'h0000_000E;
  localparam logic [31:0] PTE_A        = 32'h0000_0040;
  localparam logic [31:0] PTE_D        = 32'h0000_0080;
  localparam logic [31:0] PTE_LOW_PPN  = 32'h000F_FC00;

  typedef enum logic [1:0] {
    RK_READ       = 2'd0,
    RK_WRITE_BACK = 2'd1,
    RK_DONE       = 2'd2,
    RK_FAULT      = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ROOT = 3'b010,
    PH_LEAF = 3'b100
  } walk_phase_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] vaddr;
    logic [1:0]  access;
    logic        low_privilege;
    logic [31:0] pte_data;
  } req_t;

  typedef struct packed {
    res_kind_e   out_kind;
    logic [31:0] entry_address;
    logic [31:0] entry_value;
    logic [31:0] paddr;
    logic        in_ram;
    logic [1:0]  fault_cause;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    logic       empty;
  } fifo_status_t;

  function automatic logic within_ram(input logic [31:0] addr,
                                      input logic [31:0] base,
                                      input logic [31:0] size);
    logic [31:0] offset;
    offset = addr - base;
    return (addr >= base) && (offset < size);
  endfunction

  function automatic logic [31:0] perm_mask(input logic [1:0] acc);
    case (acc)
      ACC_READ:  return PTE_R;
      ACC_WRITE: return PTE_W;
      default:   return PTE_X;
    endcase
  endfunction

  function automatic logic [1:0] cause_of(input logic [1:0] acc);
    case (acc)
      ACC_READ:  return CAUSE_LOAD;
      ACC_WRITE: return CAUSE_STORE;
      default:   return CAUSE_FETCH;
    endcase
  endfunction

endpackage

// ===== rtl/sv32ptw_if.sv =====
// Handshake channel interfaces of the Sv32 page table walker: requests,
// results and configuration writes. Depends on sv32ptw_pkg.
interface sv32ptw_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] vaddr;
  logic [1:0]  access;
  logic        low_privilege;
  logic [31:0] pte_data;

  modport source (output valid, kind, vaddr, access, low_privilege, pte_data, input ready);
  modport sink   (input valid, kind, vaddr, access, low_privilege, pte_data, output ready);
endinterface

interface sv32ptw_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [31:0] entry_address;
  logic [31:0] entry_value;
  logic [31:0] paddr;
  logic        in_ram;
  logic [1:0]  fault_cause;
  logic        last;

  modport source (output valid, out_kind, entry_address, entry_value, paddr, in_ram,
                  fault_cause, last, input ready);
  modport sink   (input valid, out_kind, entry_address, entry_value, paddr, in_ram,
                  fault_cause, last, output ready);
endinterface

interface sv32ptw_cfg_if;
  import sv32ptw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [31:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sv32ptw_res_fifo.sv =====
// Two-entry result queue of the Sv32 page table walker; takes up to two
// items per cycle and hands out one. Depends on sv32ptw_pkg.
module sv32ptw_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_num_i,
  input  sv32ptw_pkg::res_t          item0_i,
  input  sv32ptw_pkg::res_t          item1_i,
  input  logic                       pop_i,
  output sv32ptw_pkg::res_t          head_o,
  output sv32ptw_pkg::fifo_status_t  status_o
);
  import sv32ptw_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;

  assign wr_d    = wr_q ^ push_num_i[0];
  assign rd_d    = rd_q ^ pop_i;
  assign count_d = count_q + push_num_i - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_q] <= item0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[~wr_q] <= item1_i;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == 2'd0);

endmodule

// ===== rtl/sv32ptw_core.sv =====
// Top level of the Sv32 page table walker: input register, one-pass walk
// step logic and a two-entry result queue.
// Path: an accepted item is held in the input register until the queue has room,
// is then stepped, and its results are registered in the result queue.
// Throughput: one item per cycle while the queue has room; an item that
// finishes a walk pushes two results, which the port drains at one per cycle.
// Reset: asynchronous, active low; clears the walk state, the registers
// and the queue.
module sv32_page_table_walker_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  sv32ptw_cfg_if.sink   cfg_i,
  sv32ptw_req_if.sink   req_i,
  sv32ptw_res_if.source res_o
);
  import sv32ptw_pkg::*;

  // Configuration registers. Writes are always taken.
  logic        vm_on_q;
  logic [31:0] root_base_q;
  logic [31:0] ram_begin_q;
  logic [31:0] ram_size_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_on_q     <= 1'b0;
      root_base_q <= '0;
      ram_begin_q <= '0;
      ram_size_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_VIRTUAL_MODE: vm_on_q     <= cfg_i.data[0];
        CFG_ROOT_BASE:    root_base_q <= cfg_i.data;
        CFG_RAM_BEGIN:    ram_begin_q <= cfg_i.data;
        CFG_RAM_SIZE:     ram_size_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register. It refills in the same cycle that its item is stepped,
  // so a new item can enter every cycle while the queue has room.
  req_t req_q;
  logic req_valid_q;
  logic fire;

  assign req_i.ready = !req_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.kind          <= req_i.kind;
      req_q.vaddr         <= req_i.vaddr;
      req_q.access        <= req_i.access;
      req_q.low_privilege <= req_i.low_privilege;
      req_q.pte_data      <= req_i.pte_data;
    end
  end

  // Walk state.
  walk_phase_e phase_q, phase_d;
  logic [31:0] vaddr_q, vaddr_d;
  logic [1:0]  access_q, access_d;
  logic [31:0] ptr_q, ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      vaddr_q  <= '0;
      access_q <= ACC_READ;
      ptr_q    <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      vaddr_q  <= vaddr_d;
      access_q <= access_d;
      ptr_q    <= ptr_d;
    end
  end

  // Candidate addresses. Only one of them matters for a given item, so a
  // single RAM range check is shared by selecting the address first.
  logic [31:0] pte;
  logic [1:0]  acc_norm;
  logic        passthru;
  logic        is_leaf;
  logic [31:0] root_ea;
  logic [31:0] next_ea;
  logic [31:0] super_pa;
  logic [31:0] page_pa;
  logic [31:0] chk_addr;
  logic        chk_in_ram;

  assign pte      = req_q.pte_data;
  assign acc_norm = (req_q.access == ACC_SPARE) ? ACC_FETCH : req_q.access;
  assign passthru = !vm_on_q || !req_q.low_privilege;
  assign is_leaf  = (pte & PTE_RWX) != '0;
  assign root_ea  = root_base_q | {20'b0, req_q.vaddr[31:22], 2'b00};
  assign next_ea  = {pte[29:10], vaddr_q[21:12], 2'b00};
  assign super_pa = {pte[29:20], vaddr_q[21:0]};
  assign page_pa  = {pte[29:10], vaddr_q[11:0]};

  always_comb begin
    if (!req_q.kind) begin
      chk_addr = passthru ? req_q.vaddr : root_ea;
    end else if (phase_q == PH_ROOT) begin
      chk_addr = is_leaf ? super_pa : next_ea;
    end else begin
      chk_addr = page_pa;
    end
  end

  assign chk_in_ram = within_ram(chk_addr, ram_begin_q, ram_size_q);

  // One walk step for the item in the input register.
  logic [1:0]  n_res;
  res_t        r0, r1;
  logic [31:0] perm;
  logic [1:0]  fault_acc;
  logic [31:0] upd;

  always_comb begin
    phase_d   = phase_q;
    vaddr_d   = vaddr_q;
    access_d  = access_q;
    ptr_d     = ptr_q;
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;
    perm      = perm_mask(access_q);
    fault_acc = req_q.kind ? access_q : acc_norm;
    upd       = pte | PTE_A | ((access_q == ACC_WRITE) ? PTE_D : '0);

    // A page fault item, used by every failing branch below.
    r0.out_kind    = RK_FAULT;
    r0.fault_cause = cause_of(fault_acc);
    r0.last        = 1'b1;

    if (!req_q.kind) begin
      // A new request always abandons any walk in progress.
      vaddr_d  = req_q.vaddr;
      access_d = acc_norm;
      phase_d  = PH_IDLE;
      n_res    = 2'd1;
      if (passthru) begin
        r0           = '0;
        r0.out_kind  = RK_DONE;
        r0.paddr     = req_q.vaddr;
        r0.in_ram    = chk_in_ram;
        r0.last      = 1'b1;
      end else if (chk_in_ram) begin
        r0               = '0;
        r0.out_kind      = RK_READ;
        r0.entry_address = root_ea;
        r0.last          = 1'b1;
        ptr_d            = root_ea;
        phase_d          = PH_ROOT;
      end
    end else if (phase_q != PH_IDLE) begin
      // Every response ends the walk unless it asks for the next level.
      phase_d = PH_IDLE;
      n_res   = 2'd1;
      if ((pte & PTE_V) == '0) begin
        // Invalid entry: keep the fault item.
      end else if (phase_q == PH_ROOT && !is_leaf) begin
        if (chk_in_ram) begin
          r0               = '0;
          r0.out_kind      = RK_READ;
          r0.entry_address = next_ea;
          r0.last          = 1'b1;
          ptr_d            = next_ea;
          phase_d          = PH_LEAF;
        end
      end else if ((phase_q == PH_ROOT && (pte & (perm | PTE_LOW_PPN)) == perm) ||
                   (phase_q == PH_LEAF && (pte & perm) != '0)) begin
        // Successful leaf: write the entry back, then give the address.
        n_res            = 2'd2;
        r0               = '0;
        r0.out_kind      = RK_WRITE_BACK;
        r0.entry_address = ptr_q;
        r0.entry_value   = upd;
        r1.out_kind      = RK_DONE;
        r1.paddr         = (phase_q == PH_ROOT) ? super_pa : page_pa;
        r1.in_ram        = chk_in_ram;
        r1.last          = 1'b1;
      end
    end
  end

  // Result queue and the room check that gates each step.
  res_t         head;
  fifo_status_t fifo_status;
  logic         pop;
  logic [1:0]   free_slots;
  logic [1:0]   push_num;

  assign pop        = res_o.ready && !fifo_status.empty;
  assign free_slots = 2'd2 - fifo_status.count + {1'b0, pop};
  assign fire       = req_valid_q && (n_res <= free_slots);
  assign push_num   = fire ? n_res : 2'd0;

  sv32ptw_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .item0_i    (r0),
    .item1_i    (r1),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (fifo_status)
  );

  assign res_o.valid         = !fifo_status.empty;
  assign res_o.out_kind      = head.out_kind;
  assign res_o.entry_address = head.entry_address;
  assign res_o.entry_value   = head.entry_value;
  assign res_o.paddr         = head.paddr;
  assign res_o.in_ram        = head.in_ram;
  assign res_o.fault_cause   = head.fault_cause;
  assign res_o.last          = head.last;

`ifndef SYNTHESIS
  // The queue never holds more than two items.
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.count != 2'd3)
    else $error("result queue overfilled");

  // A finished walk leaves a result valid on the result port in the next cycle.
  a_two_visible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && n_res == 2'd2) |=> res_o.valid)
    else $error("write-back and done items not queued");

  // A new request never leaves the walk waiting for a second-level entry.
  a_req_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !req_q.kind) |=> (phase_q != PH_LEAF))
    else $error("request left walk in leaf phase");
`endif

endmodule
